>>> hw/rtl/acgr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and Hann window math for the grain resynthesizer.
package acgr_pkg;

    localparam int RING_LEN_DEF = 256;
    localparam int NUM_LAGS_DEF = 128;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 2'd1;

    localparam logic [15:0] LEAK_RESET = 16'd65484;
    localparam int SCALE_W = 22;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic        start;
        logic [31:0] denom;
    } acgr_scale_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] scale;
    } acgr_scale_rsp_t;

    // sin^2 of a Q30 angle by Taylor series, rounded to Q0.16
    function automatic logic [15:0] hann_from_angle(input logic [63:0] ang);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        sq;
        logic [63:0]        w;
        logic signed [63:0] sum;
        a2   = (ang * ang) >> 30;
        term = ang;
        sum  = signed'(ang);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * a2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
        end
        sq = unsigned'(sum) * unsigned'(sum);
        w  = (sq + (64'd1 << 43)) >> 44;
        return (w > 64'd65535) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

>>> hw/rtl/autocorrelation_grain_resynth.sv
`timescale 1ns / 1ps
// Top level of the autocorrelation grain resynthesizer.
// One input word (sample, gain) yields one output word. History, autocorrelation
// and overlap-add ring sit in three RAMs with registered reads; one item is worked
// at a time. Each item runs a lag walk that reads, updates and writes back one
// autocorrelation entry per cycle through a four-stage multiply pipeline. When the
// phase accumulator wraps, a bit-serial divide and the square root of the grain
// scale follow, then one grain entry per cycle into the ring. After reset a clearing
// pass over max(RING_LEN, NUM_LAGS) addresses zeroes the RAMs before the first word
// is taken; configuration writes are taken at any time.
module autocorrelation_grain_resynth #(
    parameter int RING_LEN = acgr_pkg::RING_LEN_DEF,
    parameter int NUM_LAGS = acgr_pkg::NUM_LAGS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [acgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_in_sample,
    input  logic [15:0]                    s_env_gain,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_out_sample
);
    localparam int RingAw   = $clog2(RING_LEN);
    localparam int LagAw    = $clog2(NUM_LAGS);
    localparam int WinAw    = $clog2(2 * NUM_LAGS);
    localparam int ClrLen   = (RING_LEN > NUM_LAGS) ? RING_LEN : NUM_LAGS;
    localparam int ClrAw    = $clog2(ClrLen);
    localparam logic [RingAw-1:0] RingLast  = RingAw'(RING_LEN - 1);
    localparam logic [LagAw:0]    LagEnd    = (LagAw+1)'(NUM_LAGS);
    localparam logic [WinAw-1:0]  GrainLen  = WinAw'(2 * NUM_LAGS - 1);
    localparam logic [WinAw-1:0]  LastLag   = WinAw'(NUM_LAGS - 1);
    localparam logic [ClrAw-1:0]  ClrLast   = ClrAw'(ClrLen - 1);
    localparam logic [ClrAw:0]    ClrRing   = (ClrAw+1)'(RING_LEN);
    localparam logic [ClrAw:0]    ClrLags   = (ClrAw+1)'(NUM_LAGS);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_LAG   = 4'd2;
    localparam logic [3:0] ST_R0RD  = 4'd3;
    localparam logic [3:0] ST_R0WT  = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_GRAIN = 4'd6;
    localparam logic [3:0] ST_ORD   = 4'd7;
    localparam logic [3:0] ST_OMUL  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // control state
    logic [3:0]        state_reg;
    logic [15:0]       leak_reg;
    logic [31:0]       step_reg;
    logic [31:0]       phase_reg;
    logic              wrap_reg;
    logic [RingAw-1:0] wp_reg;
    logic [ClrAw-1:0]  clr_reg;
    logic [LagAw:0]    lag_cnt_reg;
    logic [RingAw-1:0] hist_addr_reg;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [WinAw-1:0]  ent_reg;
    logic [RingAw-1:0] gaddr_reg;
    logic              gv1_reg, gv2_reg, gv3_reg;
    logic              m_valid_reg;

    // payload
    logic signed [15:0] x0_reg;
    logic [15:0]        gain_reg;
    logic [LagAw-1:0]   l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [31:0] prod_reg, prod3_reg, r2_reg;
    logic signed [48:0] ak3_reg, ak4_reg;
    logic signed [49:0] kp4_reg;
    logic [RingAw-1:0]  ga1_reg, ga2_reg, ga3_reg;
    logic signed [31:0] rr2_reg, rr3_reg, t_reg;
    logic signed [32:0] c_reg;
    logic [acgr_pkg::SCALE_W-1:0] scale_reg;
    logic signed [48:0] yp_reg;
    logic signed [15:0] m_sample_reg;

    // RAM ports
    logic              hist_we, ac_we, ring_we;
    logic [RingAw-1:0] hist_waddr, hist_raddr, ring_waddr, ring_raddr;
    logic [LagAw-1:0]  ac_waddr, ac_raddr;
    logic [15:0]       hist_wdata, hist_rdata;
    logic [31:0]       ac_wdata, ac_rdata, ring_wdata, ring_rdata;
    logic [WinAw-1:0]  hann_idx;
    logic [15:0]       hann_w;

    acgr_pkg::acgr_scale_req_t scale_req;
    acgr_pkg::acgr_scale_rsp_t scale_rsp;

    // datapath
    logic              accept;
    logic              out_free;
    logic              lag_issue, lag_done;
    logic              g_issue, g_done;
    logic [WinAw-1:0]  ridx;
    logic signed [31:0] prod_w;
    logic signed [48:0] ak_w;
    logic [16:0]        kc_w;
    logic signed [49:0] kp_w;
    logic signed [50:0] acc_w;
    logic signed [34:0] sh_w;
    logic [31:0]        ac_new;
    logic signed [48:0] tp_w;
    logic signed [54:0] cp_w;
    logic signed [33:0] gsum_w;
    logic [31:0]        ring_new;
    logic signed [48:0] yp_w;
    logic signed [23:0] y_w;
    logic signed [15:0] y_sat;
    logic [32:0]        phase_sum;
    logic [31:0]        r0_pos;

    assign accept   = (state_reg == ST_IDLE) && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign lag_issue = (state_reg == ST_LAG) && (lag_cnt_reg != LagEnd);
    assign lag_done  = (lag_cnt_reg == LagEnd) && !v1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign g_issue   = (state_reg == ST_GRAIN) && (ent_reg != GrainLen);
    assign g_done    = (ent_reg == GrainLen) && !gv1_reg && !gv2_reg && !gv3_reg;
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};

    // mirrored lag index: R[L-1..1] then R[0..L-1]
    assign ridx = (ent_reg < LastLag) ? (LastLag - ent_reg) : (ent_reg - LastLag);

    always_comb begin
        // autocorrelation update, R = floor((R*k + (1-k)*x0*xl) / 2^16)
        prod_w = x0_reg * $signed(hist_rdata);
        ak_w   = r2_reg * $signed({1'b0, leak_reg});
        kc_w   = 17'h10000 - {1'b0, leak_reg};
        kp_w   = prod3_reg * $signed({1'b0, kc_w});
        acc_w  = {{2{ak4_reg[48]}}, ak4_reg} + {kp4_reg[49], kp4_reg};
        sh_w   = acc_w[50:16];
        if ((&sh_w[34:31]) || !(|sh_w[34:31])) begin
            ac_new = sh_w[31:0];
        end else begin
            ac_new = sh_w[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        // grain term and ring accumulate
        tp_w   = $signed(ac_rdata) * $signed({1'b0, hann_w});
        cp_w   = t_reg * $signed({1'b0, scale_reg});
        gsum_w = {{2{rr3_reg[31]}}, rr3_reg} + {c_reg[32], c_reg};
        if ((&gsum_w[33:31]) || !(|gsum_w[33:31])) begin
            ring_new = gsum_w[31:0];
        end else begin
            ring_new = gsum_w[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        // output scaling
        yp_w = $signed(ring_rdata) * $signed({1'b0, gain_reg});
        y_w  = yp_reg[48:25];
        if ((&y_w[23:15]) || !(|y_w[23:15])) begin
            y_sat = y_w[15:0];
        end else begin
            y_sat = y_w[23] ? 16'sh8000 : 16'sh7FFF;
        end
        r0_pos = ac_rdata[31] ? 32'd0 : ac_rdata;
    end

    // RAM port steering
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = wp_reg;
        hist_wdata = s_in_sample;
        ac_we      = v4_reg;
        ac_waddr   = l4_reg;
        ac_wdata   = ac_new;
        ring_we    = gv3_reg;
        ring_waddr = ga3_reg;
        ring_wdata = ring_new;
        ac_raddr   = lag_cnt_reg[LagAw-1:0];
        ring_raddr = gaddr_reg;
        hann_idx   = ent_reg + WinAw'(1);
        if (state_reg == ST_CLEAR) begin
            // zero every RAM entry, one address per cycle
            hist_we    = ({1'b0, clr_reg} < ClrRing);
            hist_waddr = clr_reg[RingAw-1:0];
            hist_wdata = '0;
            ac_we      = ({1'b0, clr_reg} < ClrLags);
            ac_waddr   = clr_reg[LagAw-1:0];
            ac_wdata   = '0;
            ring_we    = hist_we;
            ring_waddr = clr_reg[RingAw-1:0];
            ring_wdata = '0;
        end
        if (accept) begin
            hist_we = 1'b1;
        end
        if (state_reg == ST_R0RD) begin
            ac_raddr = '0;
        end
        if (state_reg == ST_GRAIN) begin
            ac_raddr = ridx[LagAw-1:0];
        end
        if (state_reg == ST_ORD) begin
            ring_raddr = wp_reg;
        end
        if ((state_reg == ST_OUT) && out_free) begin
            // hand out the entry and clear it
            ring_we    = 1'b1;
            ring_waddr = wp_reg;
            ring_wdata = '0;
        end
    end
    assign hist_raddr = hist_addr_reg;

    assign scale_req.start = (state_reg == ST_R0WT);
    assign scale_req.denom = r0_pos + 32'h0010_0000;

    acgr_ram #(.WIDTH(16), .DEPTH(RING_LEN)) u_hist (
        .aclk(aclk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .raddr(hist_raddr), .rdata(hist_rdata)
    );

    acgr_ram #(.WIDTH(32), .DEPTH(NUM_LAGS)) u_acorr (
        .aclk(aclk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
        .raddr(ac_raddr), .rdata(ac_rdata)
    );

    acgr_ram #(.WIDTH(32), .DEPTH(RING_LEN)) u_ring (
        .aclk(aclk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(ring_raddr), .rdata(ring_rdata)
    );

    acgr_hann_rom #(.NUM_LAGS(NUM_LAGS)) u_hann (
        .aclk(aclk), .idx(hann_idx), .w_out(hann_w)
    );

    acgr_scale u_scale (
        .aclk(aclk), .aresetn(aresetn), .req(scale_req), .rsp(scale_rsp)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            leak_reg      <= acgr_pkg::LEAK_RESET;
            step_reg      <= '0;
            phase_reg     <= '0;
            wrap_reg      <= 1'b0;
            wp_reg        <= '0;
            clr_reg       <= '0;
            lag_cnt_reg   <= '0;
            hist_addr_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            ent_reg       <= '0;
            gaddr_reg     <= '0;
            gv1_reg       <= 1'b0;
            gv2_reg       <= 1'b0;
            gv3_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    acgr_pkg::CFG_LEAK:  leak_reg <= cfg_wdata[15:0];
                    acgr_pkg::CFG_PHASE: step_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // advance the pipelines
            v1_reg  <= lag_issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            gv1_reg <= g_issue;
            gv2_reg <= gv1_reg;
            gv3_reg <= gv2_reg;
            if (lag_issue) begin
                lag_cnt_reg   <= lag_cnt_reg + (LagAw+1)'(1);
                hist_addr_reg <= (hist_addr_reg == '0) ? RingLast
                                                       : hist_addr_reg - RingAw'(1);
            end
            if (g_issue) begin
                ent_reg   <= ent_reg + WinAw'(1);
                gaddr_reg <= (gaddr_reg == RingLast) ? '0 : gaddr_reg + RingAw'(1);
            end

            // load a new output word, or drop the one just taken
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + ClrAw'(1);
                    if (clr_reg == ClrLast) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        phase_reg     <= phase_sum[31:0];
                        wrap_reg      <= phase_sum[32];
                        lag_cnt_reg   <= '0;
                        hist_addr_reg <= wp_reg;
                        state_reg     <= ST_LAG;
                    end
                end
                ST_LAG: begin
                    if (lag_done) begin
                        state_reg <= wrap_reg ? ST_R0RD : ST_ORD;
                    end
                end
                ST_R0RD:  state_reg <= ST_R0WT;
                ST_R0WT:  state_reg <= ST_SCALE;
                ST_SCALE: begin
                    if (scale_rsp.done) begin
                        ent_reg   <= '0;
                        gaddr_reg <= wp_reg;
                        state_reg <= ST_GRAIN;
                    end
                end
                ST_GRAIN: begin
                    if (g_done) begin
                        state_reg <= ST_ORD;
                    end
                end
                ST_ORD:  state_reg <= ST_OMUL;
                ST_OMUL: state_reg <= ST_OUT;
                ST_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        wp_reg      <= (wp_reg == RingLast) ? '0 : wp_reg + RingAw'(1);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            x0_reg   <= s_in_sample;
            gain_reg <= s_env_gain;
        end
        l1_reg    <= lag_cnt_reg[LagAw-1:0];
        l2_reg    <= l1_reg;
        l3_reg    <= l2_reg;
        l4_reg    <= l3_reg;
        prod_reg  <= prod_w;
        r2_reg    <= $signed(ac_rdata);
        ak3_reg   <= ak_w;
        prod3_reg <= prod_reg;
        ak4_reg   <= ak3_reg;
        kp4_reg   <= kp_w;
        ga1_reg   <= gaddr_reg;
        ga2_reg   <= ga1_reg;
        ga3_reg   <= ga2_reg;
        rr2_reg   <= $signed(ring_rdata);
        rr3_reg   <= rr2_reg;
        t_reg     <= tp_w[47:16];
        c_reg     <= cp_w[54:22];
        if (scale_rsp.done) begin
            scale_reg <= scale_rsp.scale;
        end
        if (state_reg == ST_OMUL) begin
            yp_reg <= yp_w;
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_sample_reg <= y_sat;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
endmodule

>>> hw/rtl/acgr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module acgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/acgr_hann_rom.sv
`timescale 1ns / 1ps
// Hann window constant table with registered read.
module acgr_hann_rom #(
    parameter int NUM_LAGS = acgr_pkg::NUM_LAGS_DEF
) (
    input  logic                          aclk,
    input  logic [$clog2(2*NUM_LAGS)-1:0] idx,
    output logic [15:0]                   w_out
);
    localparam int WinLen = 2 * NUM_LAGS;

    logic [15:0] rom [WinLen];
    logic [15:0] w_reg;

    for (genvar gi = 0; gi < WinLen; gi++) begin : g_rom
        if (gi <= NUM_LAGS) begin : g_lo
            localparam logic [63:0] ANG = (acgr_pkg::PI_Q30 * 64'(gi)) / 64'(WinLen);
            assign rom[gi] = acgr_pkg::hann_from_angle(ANG);
        end else begin : g_hi
            // mirror the rising half
            assign rom[gi] = rom[WinLen-gi];
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= rom[idx];
    end

    assign w_out = w_reg;
endmodule

>>> hw/rtl/acgr_scale.sv
`timescale 1ns / 1ps
// Grain scale unit: floor(2^62 / s) by restoring division, then integer square root.
module acgr_scale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  acgr_pkg::acgr_scale_req_t  req,
    output acgr_pkg::acgr_scale_rsp_t  rsp
);
    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_DIV  = 2'd1;
    localparam logic [1:0] SC_SQRT = 2'd2;

    logic [1:0]  st_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_reg;
    logic [43:0] quo_reg;
    logic [23:0] srem_reg;
    logic [acgr_pkg::SCALE_W-1:0] root_reg;

    logic [32:0] shifted;
    logic        qbit;
    logic [25:0] cur;
    logic [25:0] trial;
    logic        take;

    always_comb begin
        shifted = {rem_reg[31:0], (cnt_reg == 6'd62)};
        qbit    = (shifted >= {1'b0, den_reg});
        cur     = {srem_reg, quo_reg[43:42]};
        trial   = {2'b00, root_reg, 2'b01};
        take    = (cur >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= SC_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                SC_IDLE: begin
                    if (req.start) begin
                        st_reg  <= SC_DIV;
                        cnt_reg <= 6'd62;
                    end
                end
                SC_DIV: begin
                    if (cnt_reg == 6'd0) begin
                        st_reg  <= SC_SQRT;
                        cnt_reg <= 6'd21;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                SC_SQRT: begin
                    if (cnt_reg == 6'd0) begin
                        st_reg   <= SC_IDLE;
                        done_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                default: st_reg <= SC_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            SC_IDLE: begin
                den_reg  <= req.denom;
                rem_reg  <= '0;
                quo_reg  <= '0;
                srem_reg <= '0;
                root_reg <= '0;
            end
            SC_DIV: begin
                rem_reg <= qbit ? (shifted - {1'b0, den_reg}) : shifted;
                quo_reg <= {quo_reg[42:0], qbit};
            end
            SC_SQRT: begin
                srem_reg <= take ? 24'(cur - trial) : cur[23:0];
                root_reg <= {root_reg[acgr_pkg::SCALE_W-2:0], take};
                quo_reg  <= {quo_reg[41:0], 2'b00};
            end
            default: ;
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.scale = root_reg;
endmodule

>>> hw/rtl/acgr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the grain resynthesizer, bound to the top level.
module acgr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_sample
);
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready) begin
            pend_next = pend_next + 2'd1;
        end
        if (m_valid && m_ready) begin
            pend_next = pend_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample))
        else $error("output word dropped or changed while stalled");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("output word without a pending input word");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken before the first was worked");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
endmodule

bind autocorrelation_grain_resynth acgr_checker u_acgr_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_out_sample(m_out_sample)
);

>>> verif/autocorrelation_grain_resynth_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the autocorrelation grain resynthesizer top level.
module autocorrelation_grain_resynth_tb;

    localparam int RING = 256;
    localparam int LAGS = 128;
    localparam int SETTLE_CYCLES = 700;      // covers one item plus a full grain
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [15:0]        gain;
    } grain_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [acgr_pkg::CFG_IDX_W-1:0] cfg_index = acgr_pkg::CFG_LEAK;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [15:0]   s_in_sample = '0;
    logic [15:0]          s_env_gain = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [15:0]   m_out_sample;

    autocorrelation_grain_resynth dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_sample(s_in_sample), .s_env_gain(s_env_gain),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_sample(m_out_sample)
    );

    always #10 aclk = ~aclk;

    // Shadow copy of the block state
    shortint        hist_mem [RING];
    int             corr_mem [LAGS];
    int             ola_ring [RING];
    logic [15:0]    window_tab [2*LAGS];
    int unsigned    wr_pos;
    int unsigned    phase_acc;
    logic [15:0]    leak_k;
    logic [31:0]    phase_inc;

    grain_word_t        pending_words [$];
    logic signed [15:0] expected_out [$];

    int  errors = 0;
    bit  send_idle = 1'b0;      // random gaps on the input side
    bit  recv_idle = 1'b0;      // random stalls on the output side
    int  long_hold_req = 0;     // long receiver hold-off, taken by the receiver
    int  send_gap = 0;
    int  recv_hold = 0;
    bit  s_took = 1'b0;
    longint cycles = 0;

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int sat_word32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // Window: sin^2 by a Q30 Taylor series, mirrored above the center
    task automatic build_window();
        longint unsigned ang, ang2, term, sq, w;
        longint          acc;
        for (int i = 0; i <= LAGS; i++) begin
            ang  = (64'd3373259426 * longint'(i)) / (2 * LAGS);
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
                acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
            sq = longint'(acc) * longint'(acc);
            w  = (sq + (64'd1 << 43)) >> 44;
            window_tab[i] = (w > 65535) ? 16'hFFFF : w[15:0];
        end
        for (int i = LAGS + 1; i < 2 * LAGS; i++) window_tab[i] = window_tab[2*LAGS-i];
    endtask

    task automatic grain_add(input int unsigned pos, input longint r, input int unsigned wv,
                             input longint scale);
        longint t;
        t = (r * longint'(wv)) >>> 16;
        ola_ring[pos % RING] = sat_word32(longint'(ola_ring[pos % RING]) + ((t * scale) >>> 22));
    endtask

    // Advance the shadow state by one word and return the resynthesized sample
    task automatic resynth_step(input grain_word_t wd, output logic signed [15:0] y_out);
        longint      x0, kk, kc, acc, scale, y;
        longint unsigned s;
        int unsigned rd, wy;
        x0 = wd.sample;
        hist_mem[wr_pos] = wd.sample;
        kk = leak_k;
        kc = 65536 - kk;
        for (int l = 0; l < LAGS; l++) begin
            rd  = (wr_pos + RING - l) % RING;
            acc = longint'(corr_mem[l]) * kk + kc * (x0 * longint'(hist_mem[rd]));
            corr_mem[l] = sat_word32(acc >>> 16);
        end
        phase_acc = phase_acc + phase_inc;
        if (phase_acc < phase_inc) begin
            s = (corr_mem[0] < 0 ? 0 : longint'(corr_mem[0])) + (64'd1 << 20);
            scale = longint'(isqrt64((64'd1 << 62) / s));
            wy = wr_pos;
            for (int j = 1; j < LAGS; j++) begin
                grain_add(wy, corr_mem[LAGS-j], window_tab[j], scale);
                wy++;
            end
            for (int j = 0; j < LAGS; j++) begin
                grain_add(wy, corr_mem[j], window_tab[j+LAGS], scale);
                wy++;
            end
        end
        y = (longint'(ola_ring[wr_pos]) * longint'(wd.gain)) >>> 25;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        y_out = y[15:0];
        ola_ring[wr_pos] = 0;
        wr_pos = (wr_pos + 1) % RING;
    endtask

    // Predict on input acceptance, mirror register writes, check outputs
    always @(posedge aclk) begin
        logic signed [15:0] y_pred;
        logic signed [15:0] want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        s_took <= s_valid && s_ready;
        if (aresetn && cfg_we) begin
            if (cfg_index == acgr_pkg::CFG_LEAK) leak_k = cfg_wdata[15:0];
            else if (cfg_index == acgr_pkg::CFG_PHASE) phase_inc = cfg_wdata;
        end
        if (aresetn && s_valid && s_ready) begin
            resynth_step('{sample: s_in_sample, gain: s_env_gain}, y_pred);
            expected_out.push_back(y_pred);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d", $time, m_out_sample);
                errors++;
            end else begin
                want = expected_out.pop_front();
                if (want !== m_out_sample) begin
                    $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                             $time, want, m_out_sample);
                    errors++;
                end
            end
        end
    end

    // Driver: hold the word until it is taken, then advance or idle
    always @(negedge aclk) begin
        grain_word_t wd;
        if (aresetn && (!s_valid || s_took)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                wd = pending_words.pop_front();
                s_in_sample <= wd.sample;
                s_env_gain  <= wd.gain;
                s_valid     <= 1'b1;
                if (send_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random short stalls, or one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else if (long_hold_req > 0) begin
            recv_hold = long_hold_req - 1;
            long_hold_req = 0;
            m_ready <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            recv_hold = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [acgr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every queued word is out and the block has gone quiet
    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_out.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_word(input logic signed [15:0] smp, input logic [15:0] g);
        pending_words.push_back('{sample: smp, gain: g});
    endtask

    task automatic push_random(input int count);
        logic signed [15:0] smp;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: smp = 16'($urandom_range(0, 65535));
                1: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: smp = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
            endcase
            push_word(smp, $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        for (int i = 0; i < RING; i++) begin
            hist_mem[i] = 0;
            ola_ring[i] = 0;
        end
        for (int i = 0; i < LAGS; i++) corr_mem[i] = 0;
        build_window();
        wr_pos = 0;
        phase_acc = 0;
        leak_k = acgr_pkg::LEAK_RESET;
        phase_inc = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero phase step first, so no grain is added
        push_word(16'sh7FFF, 16'hFFFF);
        push_word(16'sh8000, 16'hFFFF);
        push_word(16'sh0000, 16'h0000);
        push_word(-16'sd1, 16'h8000);
        drain();
        // Out-of-range register indexes must be dropped
        reg_write(2'd2, 32'hFFFF_FFFF);
        reg_write(2'd3, 32'h0000_0001);
        reg_write(acgr_pkg::CFG_PHASE, 32'h8000_0000);   // grain every second word
        for (int i = 0; i < 8; i++) push_word(i[0] ? 16'sh7FFF : 16'sh8000, 16'hFFFF);
        for (int i = 0; i < 8; i++) push_word(16'sh7FFF, i[0] ? 16'h0000 : 16'h0001);
        drain();

        // Extremes: no smoothing memory, grain on nearly every word
        reg_write(acgr_pkg::CFG_LEAK, 32'h0000_0000);
        reg_write(acgr_pkg::CFG_PHASE, 32'hFFFF_FFFF);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        push_random(170);
        drain();

        // Full smoothing, long receiver hold-off while the sender keeps offering
        reg_write(acgr_pkg::CFG_LEAK, 32'h0000_FFFF);
        reg_write(acgr_pkg::CFG_PHASE, 32'h1000_0000);
        push_random(170);
        @(posedge aclk);
        long_hold_req = 3000;
        drain();

        reg_write(acgr_pkg::CFG_LEAK, 32'h0000_7530);
        reg_write(acgr_pkg::CFG_PHASE, $urandom());
        push_random(170);
        drain();

        reg_write(acgr_pkg::CFG_LEAK, 32'h0000_FFCC);
        reg_write(acgr_pkg::CFG_PHASE, 32'h0000_0000);
        push_random(170);
        drain();

        reg_write(acgr_pkg::CFG_LEAK, $urandom_range(0, 65535));
        reg_write(acgr_pkg::CFG_PHASE, 32'h4000_0000);
        push_random(170);
        drain();

        // Closing stretch at full rate
        send_idle = 1'b0;
        recv_idle = 1'b0;
        reg_write(acgr_pkg::CFG_PHASE, 32'h2AAA_AAAB);
        push_random(180);
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
